[hw/rtl/seven_segment_number_scanner_top_assert.svh]
// Assertion macros for the scanner's checker file.
`ifndef SEVEN_SEGMENT_NUMBER_SCANNER_TOP_ASSERT_SVH
`define SEVEN_SEGMENT_NUMBER_SCANNER_TOP_ASSERT_SVH

// Clocked assertion with a synchronous reset that masks the check.
`define NSS_ASSERT_CLK(lbl, clk_sig, rst_sig, prop, msg) \
  lbl: assert property (@(posedge clk_sig) disable iff (rst_sig) prop) else $error(msg);

// Shorthand for checkers whose clock and reset are named clk and rst.
`define NSS_ASSERT(lbl, prop, msg) \
  `NSS_ASSERT_CLK(lbl, clk, rst, prop, msg)

`endif

[hw/rtl/nss_pkg.sv]
// Types and constants shared by the seven-segment number scanner.
package nss_pkg;

  // Item kinds
  typedef enum logic [1:0] {
    OP_INT_SET   = 2'd0,
    OP_FIX_SET   = 2'd1,
    OP_AUTO_SET  = 2'd2,
    OP_SCAN_TICK = 2'd3
  } op_t;

  // Base codes for an integer set
  localparam logic [1:0] BASE_OCT = 2'd0;
  localparam logic [1:0] BASE_DEC = 2'd1;
  localparam logic [1:0] BASE_HEX = 2'd2;
  localparam logic [1:0] BASE_BAD = 2'd3;

  // Decimal places; this code only clears the dots
  localparam logic [1:0] PLACES_CLEAR = 2'd3;

  // Fixed-point constants
  localparam int          FRAC_BITS = 8;
  localparam logic [24:0] TEN_Q     = 25'd2560;
  localparam logic [24:0] HUNDRED_Q = 25'd25600;
  localparam logic [15:0] SAT_MAX   = 16'hFFFF;

  // x / 10 == (x * 52429) >> 19 for every 16-bit x
  localparam logic [16:0] DIV10_MUL   = 17'd52429;
  localparam int          DIV10_SHIFT = 19;

  // Scan position that shows the degree symbol
  localparam logic [1:0] POS_DEGREE = 2'd3;

  // Controller to datapath commands
  typedef struct packed {
    logic load_int;
    logic load_fix;
    logic load_auto;
    logic scan;
    logic scale;
    logic saturate;
    logic split;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic places_skip;
    logic last_digit;
    logic out_busy;
  } status_t;

endpackage

[hw/rtl/nss_if.sv]
// Valid/ready channel interfaces for set/scan items and scan results.
interface nss_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         op;
  logic [15:0]        value;
  logic [1:0]         base_code;
  logic signed [24:0] fixed_value;
  logic [1:0]         decimals;

  modport source (output valid, op, value, base_code, fixed_value, decimals, input ready);
  modport sink   (input valid, op, value, base_code, fixed_value, decimals, output ready);
endinterface

interface nss_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] position;
  logic [3:0] digit_value;
  logic       dot_on;
  logic       degree_on;

  modport source (output valid, position, digit_value, dot_on, degree_on, input ready);
  modport sink   (input valid, position, digit_value, dot_on, degree_on, output ready);
endinterface

[hw/rtl/nss_ctrl.sv]
// Sequencing state machine: load, scale and saturate (fixed sets only), then one digit per cycle.
module nss_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [1:0]      op,
  input  logic [1:0]      base_code,
  input  nss_pkg::status_t status,
  output nss_pkg::cmd_t   cmd
);
  import nss_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCALE,
    ST_SAT,
    ST_SPLIT
  } state_t;

  state_t state, state_next;
  logic   accept;

  // Scan ticks wait for a free result register; sets never do
  assign in_ready = (state == ST_IDLE) &&
                    ((op != OP_SCAN_TICK) || !status.out_busy);
  assign accept   = in_valid && in_ready;

  // Commands and next state
  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (op_t'(op))
            OP_INT_SET: begin
              if (base_code != BASE_BAD) begin
                cmd.load_int = 1'b1;
                state_next   = ST_SPLIT;
              end
            end
            OP_FIX_SET: begin
              cmd.load_fix = 1'b1;
              state_next   = ST_SCALE;
            end
            OP_AUTO_SET: begin
              cmd.load_auto = 1'b1;
              state_next    = ST_SCALE;
            end
            OP_SCAN_TICK: cmd.scan = 1'b1;
            default: ;
          endcase
        end
      end
      ST_SCALE: begin
        if (status.places_skip) begin
          state_next = ST_IDLE;
        end else begin
          cmd.scale  = 1'b1;
          state_next = ST_SAT;
        end
      end
      ST_SAT: begin
        cmd.saturate = 1'b1;
        state_next   = ST_SPLIT;
      end
      ST_SPLIT: begin
        cmd.split = 1'b1;
        if (status.last_digit) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

[hw/rtl/nss_datapath.sv]
// Digit and dot stores, fixed-point scaler, digit splitter and scan output.
module nss_datapath #(
  parameter int NUM_DIGITS = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  nss_pkg::cmd_t      cmd,
  output nss_pkg::status_t   status,
  input  logic [15:0]        value,
  input  logic [1:0]         base_code,
  input  logic signed [24:0] fixed_value,
  input  logic [1:0]         decimals,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         position,
  output logic [3:0]         digit_value,
  output logic               dot_on,
  output logic               degree_on
);
  import nss_pkg::*;

  localparam int IW = $clog2(NUM_DIGITS);

  logic [3:0]    digit_store [NUM_DIGITS];
  logic [NUM_DIGITS-1:0] dot_store;
  logic [1:0]    scan_position;

  logic [24:0]   mag;
  logic [1:0]    places;
  logic [1:0]    radix;
  logic          fix_mode;
  logic [15:0]   work;
  logic [31:0]   prod;
  logic [IW-1:0] idx;

  logic [24:0]   raw_bits;
  logic [24:0]   mag_in;
  logic [1:0]    auto_places;
  logic [6:0]    scale_k;
  logic [23:0]   scaled;
  logic [32:0]   div10_prod;
  logic [15:0]   q10;
  logic [15:0]   quot;
  logic [3:0]    rem;
  logic [1:0]    pos_next;
  logic [3:0]    digit_sel;
  logic          dot_sel;

  // Magnitude and auto-range place count from the incoming value
  always_comb begin
    raw_bits = fixed_value;
    mag_in   = raw_bits[24] ? (~raw_bits + 25'd1) : raw_bits;
    if (raw_bits[24] || (raw_bits < TEN_Q)) auto_places = 2'd2;
    else if (raw_bits < HUNDRED_Q)          auto_places = 2'd1;
    else                                    auto_places = 2'd0;
  end

  // Scale factor 1, 10 or 100
  always_comb begin
    case (places)
      2'd0:    scale_k = 7'd1;
      2'd1:    scale_k = 7'd10;
      default: scale_k = 7'd100;
    endcase
  end

  assign scaled = prod[31:FRAC_BITS];

  // One digit per step: shifts for base 8 and 16, reciprocal multiply for 10
  always_comb begin
    div10_prod = {17'd0, work} * {16'd0, DIV10_MUL};
    q10        = 16'(div10_prod >> DIV10_SHIFT);
    case (radix)
      BASE_OCT: begin
        quot = work >> 3;
        rem  = {1'b0, work[2:0]};
      end
      BASE_HEX: begin
        quot = work >> 4;
        rem  = work[3:0];
      end
      default: begin
        quot = q10;
        rem  = 4'(work - ((q10 << 3) + (q10 << 1)));
      end
    endcase
  end

  // Digit and dot at the next scan position
  always_comb begin
    pos_next  = scan_position + 2'd1;
    digit_sel = 4'd0;
    dot_sel   = 1'b0;
    if (pos_next != POS_DEGREE) begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
        if (int'(pos_next) == i) begin
          digit_sel = digit_store[i];
          dot_sel   = dot_store[i];
        end
      end
    end
  end

  assign status.places_skip = (places == PLACES_CLEAR);
  assign status.last_digit  = (idx == IW'(NUM_DIGITS - 1));
  assign status.out_busy    = out_valid && !out_ready;

  // Stores, scan position and result beat
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_DIGITS; i++) digit_store[i] <= 4'd0;
      dot_store     <= '0;
      scan_position <= 2'd0;
      out_valid     <= 1'b0;
    end else begin
      if (cmd.load_int || cmd.load_fix || cmd.load_auto) dot_store <= '0;
      if (cmd.split) begin
        for (int i = 0; i < NUM_DIGITS; i++) begin
          if (int'(idx) == i) digit_store[i] <= rem;
        end
        if (status.last_digit && fix_mode && places != 2'd0) begin
          for (int i = 0; i < NUM_DIGITS; i++) begin
            if (int'(places) == i) dot_store[i] <= 1'b1;
          end
        end
      end
      if (cmd.scan) begin
        scan_position <= pos_next;
        out_valid     <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Working registers and result payload
  always_ff @(posedge clk) begin
    if (cmd.load_int) begin
      work     <= value;
      radix    <= base_code;
      fix_mode <= 1'b0;
      idx      <= '0;
    end
    if (cmd.load_fix || cmd.load_auto) begin
      mag      <= mag_in;
      places   <= cmd.load_auto ? auto_places : decimals;
      radix    <= BASE_DEC;
      fix_mode <= 1'b1;
      idx      <= '0;
    end
    if (cmd.scale) prod <= {7'd0, mag} * {25'd0, scale_k};
    if (cmd.saturate) work <= (|scaled[23:16]) ? SAT_MAX : scaled[15:0];
    if (cmd.split) begin
      work <= quot;
      idx  <= idx + IW'(1);
    end
    if (cmd.scan) begin
      position    <= pos_next;
      digit_value <= digit_sel;
      dot_on      <= dot_sel;
      degree_on   <= (pos_next == POS_DEGREE);
    end
  end

endmodule

[hw/rtl/seven_segment_number_scanner_top.sv]
// Top level of the seven-segment number scanner: controller plus datapath.
// Usage:
//   req carries one item per beat: an integer set (value, base_code), a
//   fixed set (fixed_value, decimals), an auto-range fixed set
//   (fixed_value) or a scan tick. rsp carries one result beat per scan
//   tick: position, digit_value, dot_on, degree_on.
//   A scan tick is served in the cycle it is accepted; its result shows on
//   rsp the next cycle and the block is ready again at once.
//   An integer set is split one digit per cycle by the shared
//   divide-by-radix step. A fixed set steps through accept, multiply by
//   1/10/100, saturate, then the digit steps; decimals 3 returns to idle
//   from the scale state and only clears the dots. An invalid base is a no-op.
//   Reset clears all digits, dots and the scan position; the first tick
//   after reset reports position 1.
//   If rsp stalls, the result is held; set items are still accepted and a
//   further scan tick waits until the pending result is taken.
module seven_segment_number_scanner_top #(
  parameter int NUM_DIGITS = 4
) (
  input logic       clk,
  input logic       rst,
  nss_in_if.sink    req,
  nss_out_if.source rsp
);
  import nss_pkg::*;

  cmd_t    cmd;
  status_t status;

  nss_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .op        (req.op),
    .base_code (req.base_code),
    .status    (status),
    .cmd       (cmd)
  );

  nss_datapath #(
    .NUM_DIGITS (NUM_DIGITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .value       (req.value),
    .base_code   (req.base_code),
    .fixed_value (req.fixed_value),
    .decimals    (req.decimals),
    .out_valid   (rsp.valid),
    .out_ready   (rsp.ready),
    .position    (rsp.position),
    .digit_value (rsp.digit_value),
    .dot_on      (rsp.dot_on),
    .degree_on   (rsp.degree_on)
  );

endmodule

[hw/rtl/nss_checker.sv]
// Port-level checks on the scanner, bound to its top level.
`include "seven_segment_number_scanner_top_assert.svh"

module nss_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic [1:0] op,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] position,
  input logic [3:0] digit_value,
  input logic       dot_on,
  input logic       degree_on
);
  import nss_pkg::*;

  logic tick_beat;
  assign tick_beat = in_valid && in_ready && (op == OP_SCAN_TICK);

  // A stalled result beat stays offered
  `NSS_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result dropped while stalled")
  // Every scan tick yields a result beat the next cycle
  `NSS_ASSERT(a_tick_result, tick_beat |=> out_valid, "scan tick gave no result")
  // A new result beat only follows a scan tick
  `NSS_ASSERT(a_no_spurious, $rose(out_valid) |-> $past(tick_beat), "result without scan tick")
  // Degree symbol exactly at the degree position, with a blank digit
  `NSS_ASSERT(a_degree_pos, out_valid |-> (degree_on == (position == POS_DEGREE)) && (!degree_on || (digit_value == 4'd0 && !dot_on)), "degree symbol misplaced")

endmodule

bind seven_segment_number_scanner_top nss_checker u_nss_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (req.valid),
  .in_ready    (req.ready),
  .op          (req.op),
  .out_valid   (rsp.valid),
  .out_ready   (rsp.ready),
  .position    (rsp.position),
  .digit_value (rsp.digit_value),
  .dot_on      (rsp.dot_on),
  .degree_on   (rsp.degree_on)
);

[tb/sv/tb_seven_segment_number_scanner_top.sv]
// Self-checking testbench for the seven-segment number scanner: table-driven and random beats.
`timescale 1ns / 1ps

module tb_seven_segment_number_scanner_top;
  import nss_pkg::*;

  localparam int NDIG          = 4;
  localparam int RANDOM_ITEMS  = 1800;
  localparam int QUIET_ITEMS   = 200;   // tail of the run with no idling
  localparam int HOLD_AT       = 300;   // random beats sent before the long rsp hold-off
  localparam int HOLD_CYCLES   = 300;
  localparam int WATCHDOG_MAX  = 4000;  // cycles with no beat on either channel
  localparam int DRAIN_CYCLES  = 20;

  typedef struct packed {
    op_t                op;
    logic [15:0]        value;
    logic [1:0]         base_code;
    logic signed [24:0] fixed_value;
    logic [1:0]         decimals;
  } scan_item_t;

  typedef struct packed {
    logic [1:0] position;
    logic [3:0] digit_value;
    logic       dot_on;
    logic       degree_on;
  } scan_result_t;

  typedef struct packed {
    scan_item_t   item;
    bit           typed;
    scan_result_t res;
  } dir_row_t;

  logic clk;
  logic rst;

  nss_in_if  req_ch ();
  nss_out_if rsp_ch ();

  seven_segment_number_scanner_top #(
    .NUM_DIGITS(NDIG)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  // Clock, 10 ns period
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Shadow copy of the display state
  logic [3:0] shadow_digits [NDIG];
  logic       shadow_dots   [NDIG];
  logic [1:0] shadow_pos;

  scan_result_t expected_scans [$];
  dir_row_t     dir_rows [$];

  int  errors;
  int  random_sent;
  bit  quiet_tail;
  bit  hold_done;
  int  n_int, n_fix, n_auto, n_tick, n_degree, n_checked;

  // Split a value into digits, least significant first; clears the dots
  function automatic void load_digits(input logic [15:0] v, input int radix);
    int rem;
    int i;
    rem = v;
    for (i = 0; i < NDIG; i++) begin
      shadow_digits[i] = 4'(rem % radix);
      rem = rem / radix;
      shadow_dots[i] = 1'b0;
    end
  endfunction

  // Magnitude, scale by 1/10/100 with floor, saturate, then a decimal split; places 3 only clears the dots
  function automatic void load_fixed(input logic [24:0] raw, input logic [1:0] places);
    logic [25:0]     mag;
    longint unsigned scaled;
    int              factor;
    int              i;
    mag = raw[24] ? (26'h2000000 - {1'b0, raw}) : {1'b0, raw};
    for (i = 0; i < NDIG; i++) shadow_dots[i] = 1'b0;
    if (places == PLACES_CLEAR) return;
    factor = (places == 2'd0) ? 1 : (places == 2'd1) ? 10 : 100;
    scaled = (longint'(mag) * factor) >> FRAC_BITS;
    if (scaled > SAT_MAX) scaled = SAT_MAX;
    load_digits(scaled[15:0], 10);
    if (places != 2'd0 && int'(places) < NDIG) shadow_dots[places] = 1'b1;
  endfunction

  // Advance the shadow state by one beat; returns 1 when a result is due
  function automatic bit predict_scan(input scan_item_t it, output scan_result_t res);
    logic [24:0] raw;
    logic [1:0]  places;
    bit          has;
    res = '0;
    has = 1'b0;
    raw = it.fixed_value;
    case (it.op)
      OP_INT_SET: begin
        if (it.base_code != BASE_BAD)
          load_digits(it.value, (it.base_code == BASE_OCT) ? 8 :
                                (it.base_code == BASE_DEC) ? 10 : 16);
      end
      OP_FIX_SET: load_fixed(raw, it.decimals);
      OP_AUTO_SET: begin
        // negative values count as below ten
        if (raw[24] || raw < TEN_Q) places = 2'd2;
        else if (raw < HUNDRED_Q)    places = 2'd1;
        else                         places = 2'd0;
        load_fixed(raw, places);
      end
      default: begin
        shadow_pos = shadow_pos + 2'd1;
        res.position = shadow_pos;
        if (shadow_pos == POS_DEGREE) begin
          res.degree_on = 1'b1;
        end else if (int'(shadow_pos) < NDIG) begin
          res.digit_value = shadow_digits[shadow_pos];
          res.dot_on      = shadow_dots[shadow_pos];
        end
        has = 1'b1;
      end
    endcase
    return has;
  endfunction

  function automatic void check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      errors++;
    end
  endfunction

  // Directed table helpers
  task automatic row_set(input op_t op, input logic [15:0] v, input logic [1:0] bc,
                         input int fv, input logic [1:0] dec);
    dir_row_t r;
    r = '0;
    r.item = '{op, v, bc, 25'(fv), dec};
    dir_rows.push_back(r);
  endtask

  task automatic row_tick(input bit typed, input logic [1:0] p, input logic [3:0] d,
                          input logic dt, input logic dg);
    dir_row_t r;
    r = '0;
    r.item.op = OP_SCAN_TICK;
    r.item.value = 16'($urandom());
    r.item.fixed_value = 25'($urandom());
    r.typed = typed;
    r.res = '{p, d, dt, dg};
    dir_rows.push_back(r);
  endtask

  function automatic scan_item_t random_item();
    scan_item_t it;
    int r;
    int pick;
    it.value       = 16'($urandom());
    it.base_code   = 2'($urandom_range(0, 3));
    it.decimals    = 2'($urandom_range(0, 3));
    it.fixed_value = 25'($urandom());
    r = $urandom_range(0, 19);
    if (r < 10)      it.op = OP_SCAN_TICK;
    else if (r < 13) it.op = OP_INT_SET;
    else if (r < 17) it.op = OP_FIX_SET;
    else             it.op = OP_AUTO_SET;
    if ($urandom_range(0, 7) == 0) it.value = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
    case ($urandom_range(0, 7))
      1: it.fixed_value = 25'($urandom_range(0, 3000));
      2: begin
        pick = $urandom_range(0, 1) ? int'(TEN_Q) : int'(HUNDRED_Q);
        it.fixed_value = 25'(pick + int'($urandom_range(0, 6)) - 3);
      end
      3: it.fixed_value = 25'(-int'($urandom_range(1, 30000)));
      4: begin
        case ($urandom_range(0, 3))
          0: it.fixed_value = 25'sh0FFFFFF;
          1: it.fixed_value = 25'sh1000000;
          2: it.fixed_value = 25'sd0;
          default: it.fixed_value = -25'sd1;
        endcase
      end
      5: it.fixed_value = 25'($urandom_range(0, 102400));
      default: ;
    endcase
    return it;
  endfunction

  // Offer one beat on req, wait for it to be taken, then record what it predicts
  task automatic drive_item(input scan_item_t it, input bit typed, input scan_result_t typed_res);
    scan_result_t res;
    bit has;
    if (!quiet_tail && $urandom_range(0, 4) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.op          <= it.op;
    req_ch.value       <= it.value;
    req_ch.base_code   <= it.base_code;
    req_ch.fixed_value <= it.fixed_value;
    req_ch.decimals    <= it.decimals;
    do @(posedge clk); while (!req_ch.ready);
    has = predict_scan(it, res);
    if (has) expected_scans.push_back(typed ? typed_res : res);
    case (it.op)
      OP_INT_SET:  n_int++;
      OP_FIX_SET:  n_fix++;
      OP_AUTO_SET: n_auto++;
      default:     n_tick++;
    endcase
    @(negedge clk);
  endtask

  // Stimulus
  initial begin
    scan_item_t it;
    int i;
    rst                = 1'b1;
    req_ch.valid       = 1'b0;
    req_ch.op          = OP_INT_SET;
    req_ch.value       = '0;
    req_ch.base_code   = BASE_OCT;
    req_ch.fixed_value = '0;
    req_ch.decimals    = '0;
    errors = 0;
    random_sent = 0;
    quiet_tail = 1'b0;
    for (i = 0; i < NDIG; i++) begin
      shadow_digits[i] = '0;
      shadow_dots[i]   = 1'b0;
    end
    shadow_pos = '0;

    // after reset everything reads zero, position starts at 1
    row_tick(1, 2'd1, 4'd0, 0, 0);
    row_tick(1, 2'd2, 4'd0, 0, 0);
    row_tick(1, POS_DEGREE, 4'd0, 0, 1);
    row_set(OP_INT_SET, 16'hFFFF, BASE_HEX, 0, 2'd0);
    row_tick(1, 2'd0, 4'hF, 0, 0);
    row_tick(1, 2'd1, 4'hF, 0, 0);
    // invalid base leaves the digits alone
    row_set(OP_INT_SET, 16'd12345, BASE_BAD, 0, 2'd0);
    row_tick(1, 2'd2, 4'hF, 0, 0);
    // largest positive, two places: saturates to 65535, point on digit 2
    row_set(OP_FIX_SET, 16'd0, BASE_DEC, 16777215, 2'd2);
    row_tick(1, POS_DEGREE, 4'd0, 0, 1);
    row_tick(1, 2'd0, 4'd5, 0, 0);
    row_tick(1, 2'd1, 4'd3, 0, 0);
    row_tick(1, 2'd2, 4'd5, 1, 0);
    // three places only clears the dots
    row_set(OP_FIX_SET, 16'd0, BASE_DEC, 32'h0ABCDE, PLACES_CLEAR);
    row_tick(0, 0, 0, 0, 0);
    row_tick(0, 0, 0, 0, 0);
    row_tick(0, 0, 0, 0, 0);
    row_tick(0, 0, 0, 0, 0);
    // negative auto-range gets two places
    row_set(OP_AUTO_SET, 16'd0, BASE_DEC, -1, 2'd0);
    row_tick(0, 0, 0, 0, 0);
    row_tick(0, 0, 0, 0, 0);
    // exactly ten: one place
    row_set(OP_AUTO_SET, 16'd0, BASE_DEC, int'(TEN_Q), 2'd0);
    row_tick(0, 0, 0, 0, 0);
    row_tick(0, 0, 0, 0, 0);
    // most negative, no places; then octal and auto-range just below one hundred
    row_set(OP_FIX_SET, 16'd0, BASE_DEC, -16777216, 2'd0);
    row_tick(0, 0, 0, 0, 0);
    row_set(OP_INT_SET, 16'hFFFF, BASE_OCT, 0, 2'd0);
    row_tick(0, 0, 0, 0, 0);
    row_set(OP_AUTO_SET, 16'd0, BASE_DEC, int'(HUNDRED_Q) - 1, 2'd0);
    row_tick(0, 0, 0, 0, 0);

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_rows[k]) drive_item(dir_rows[k].item, dir_rows[k].typed, dir_rows[k].res);

    // random part
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 2) begin
        // sender stops until every result is back
        req_ch.valid <= 1'b0;
        do @(negedge clk); while (expected_scans.size() != 0);
      end
      if (i == RANDOM_ITEMS - QUIET_ITEMS) quiet_tail = 1'b1;
      it = random_item();
      drive_item(it, 1'b0, '0);
      random_sent++;
    end
    req_ch.valid <= 1'b0;

    while (expected_scans.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d integer sets, %0d fixed sets, %0d auto-range sets, %0d scan ticks.",
             n_int, n_fix, n_auto, n_tick);
    $display("%0d scan results checked, %0d of them at the degree position.",
             n_checked, n_degree);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Result side: random stalls, one long hold-off, none in the tail
  initial begin
    rsp_ch.ready = 1'b0;
    hold_done    = 1'b0;
    @(negedge rst);
    forever begin
      @(negedge clk);
      if (!hold_done && random_sent >= HOLD_AT) begin
        hold_done = 1'b1;
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        rsp_ch.ready <= 1'b1;
      end else if (quiet_tail) begin
        rsp_ch.ready <= 1'b1;
      end else if ($urandom_range(0, 7) == 0) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 12) - 1) @(negedge clk);
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // Result checker
  always @(posedge clk) begin
    scan_result_t exp_r;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (expected_scans.size() == 0) begin
        $display("%0t ns: result beat with nothing expected, actual pos %0d digit %0d dot %0d deg %0d",
                 $time, rsp_ch.position, rsp_ch.digit_value, rsp_ch.dot_on, rsp_ch.degree_on);
        errors++;
      end else begin
        exp_r = expected_scans.pop_front();
        check_field("position", exp_r.position, rsp_ch.position);
        check_field("digit_value", exp_r.digit_value, rsp_ch.digit_value);
        check_field("dot_on", exp_r.dot_on, rsp_ch.dot_on);
        check_field("degree_on", exp_r.degree_on, rsp_ch.degree_on);
        n_checked++;
        if (exp_r.degree_on) n_degree++;
      end
    end
  end

  // Watchdog on cycles without any beat
  always @(posedge clk) begin
    int quiet_cycles;
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_MAX) begin
        $display("%0t ns: no beat for %0d cycles, %0d results outstanding",
                 $time, quiet_cycles, expected_scans.size());
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/nss_pkg.sv
hw/rtl/nss_if.sv
hw/rtl/nss_ctrl.sv
hw/rtl/nss_datapath.sv
hw/rtl/seven_segment_number_scanner_top.sv
hw/rtl/nss_checker.sv
tb/sv/tb_seven_segment_number_scanner_top.sv
